/* hw/rtl/srsw_pkg.sv */
// -----------------------------------------------------------------------------
// srsw_pkg
// Shared constants and controller/datapath link types for the selective-repeat
// sender window.
// -----------------------------------------------------------------------------
package srsw_pkg;

  localparam int unsigned FRAME_W = 16;   // frame number width
  localparam int unsigned MAX_WIN = 16;   // window slots
  localparam int unsigned IDX_W   = 4;    // slot index width
  localparam int unsigned CNT_W   = 5;    // slot counter, holds MAX_WIN itself
  localparam int unsigned WIN_W   = 5;    // window_size register width
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [FRAME_W-1:0] FRAME_MAX   = 16'hFFFF;
  localparam logic [FRAME_W-1:0] TOTAL_LIMIT = 16'hFFFE;
  localparam logic [FRAME_W-1:0] FRAME_ONE   = 16'd1;

  localparam logic [FRAME_W-1:0] TOTAL_RST  = 16'd8;
  localparam logic [WIN_W-1:0]   WINDOW_RST = 5'd4;

  // input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_ROUND = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_TOTAL  = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  typedef struct packed {
    logic accept;       // input request taken
    logic clear_win;    // start command: clear window
    logic begin_round;  // admit new frames
    logic scan_step;    // advance slot counter
    logic scan_emit;    // load frame result
    logic slide_step;   // drop acknowledged base frame
    logic slide_end;    // pull next up to base
    logic emit_sum;     // load summary result
  } srsw_cmd_t;

  typedef struct packed {
    logic start_cmd;    // pending input is a start
    logic round_done;   // base already past total
    logic scan_end;     // slot counter past in-flight frames
    logic scan_acked;   // current slot already acknowledged
    logic slide_more;   // base can slide
    logic out_free;     // output register can take a result
  } srsw_status_t;

endpackage

/* hw/rtl/srsw_regs.sv */
// -----------------------------------------------------------------------------
// srsw_regs
// APB-style configuration registers: total frame count and window size.
// -----------------------------------------------------------------------------
module srsw_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srsw_pkg::ADDR_W-1:0]  paddr,
  input  logic [srsw_pkg::DATA_W-1:0]  pwdata,
  output logic [srsw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [srsw_pkg::FRAME_W-1:0] total_o,
  output logic [srsw_pkg::WIN_W-1:0]   window_o
);
  import srsw_pkg::*;

  logic [FRAME_W-1:0] total_q;
  logic [WIN_W-1:0]   window_q;
  logic               wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= TOTAL_RST;
      window_q <= WINDOW_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_TOTAL) begin
        total_q <= pwdata[FRAME_W-1:0];
      end else begin
        window_q <= pwdata[WIN_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_TOTAL) begin
      prdata = {{(DATA_W-FRAME_W){1'b0}}, total_q};
    end else begin
      prdata = {{(DATA_W-WIN_W){1'b0}}, window_q};
    end
  end

  assign total_o  = total_q;
  assign window_o = window_q;

endmodule

/* hw/rtl/srsw_ctrl.sv */
// -----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: accept, scan slots and slide base (round only), summarise.
// -----------------------------------------------------------------------------
module srsw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  srsw_pkg::srsw_status_t status_i,
  output srsw_pkg::srsw_cmd_t    cmd_o
);
  import srsw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SLIDE = 4'b0100,
    S_SUM   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.start_cmd) begin
            cmd_o.clear_win = 1'b1;
            state_d         = S_SUM;
          end else if (status_i.round_done) begin
            state_d = S_SUM;
          end else begin
            cmd_o.begin_round = 1'b1;
            state_d           = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (status_i.scan_end) begin
          state_d = S_SLIDE;
        end else if (status_i.scan_acked) begin
          cmd_o.scan_step = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.scan_emit = 1'b1;
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SLIDE: begin
        if (status_i.slide_more) begin
          cmd_o.slide_step = 1'b1;
        end else begin
          cmd_o.slide_end = 1'b1;
          state_d         = S_SUM;
        end
      end
      S_SUM: begin
        if (status_i.out_free) begin
          cmd_o.emit_sum = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/srsw_dp.sv */
// -----------------------------------------------------------------------------
// srsw_dp
// Window datapath: base/next counters, acknowledge flags, slot counter and the
// output register.
// -----------------------------------------------------------------------------
module srsw_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  srsw_pkg::srsw_cmd_t          cmd_i,
  output srsw_pkg::srsw_status_t       status_o,
  input  logic [srsw_pkg::FRAME_W-1:0] total_i,
  input  logic [srsw_pkg::WIN_W-1:0]   window_i,
  input  logic                         in_cmd_i,
  input  logic [srsw_pkg::MAX_WIN-1:0] in_delivered_mask_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srsw_pkg::FRAME_W-1:0] out_frame_number_o,
  output logic                         out_is_new_o,
  output logic                         out_delivered_o,
  output logic                         out_is_summary_o,
  output logic [srsw_pkg::FRAME_W-1:0] out_window_base_o,
  output logic                         out_base_moved_o,
  output logic                         out_all_done_o,
  output logic                         out_last_o
);
  import srsw_pkg::*;

  logic [FRAME_W-1:0] base_q, next_q, next_d;
  logic [MAX_WIN-1:0] acked_q;
  logic [FRAME_W-1:0] old_base_q, old_next_q;
  logic [MAX_WIN-1:0] mask_q;
  logic [CNT_W-1:0]   k_q;

  logic               out_valid_q;
  logic [FRAME_W-1:0] frame_num_q, win_base_q;
  logic               is_new_q, deliv_q, summary_q, moved_q, done_q;

  logic [FRAME_W-1:0] total_sat;
  logic [WIN_W-1:0]   win_eff;
  logic [FRAME_W:0]   limit_raw, frame_cur;
  logic [FRAME_W-1:0] limit_c;
  logic [IDX_W-1:0]   k_idx;
  logic               out_free;

  // clamp registers to legal ranges
  assign total_sat = (total_i == FRAME_MAX) ? TOTAL_LIMIT : total_i;
  always_comb begin
    if (window_i == '0) begin
      win_eff = WIN_W'(1);
    end else if (window_i > WIN_W'(MAX_WIN)) begin
      win_eff = WIN_W'(MAX_WIN);
    end else begin
      win_eff = window_i;
    end
  end

  // admission limit: base + win - 1, capped at total
  assign limit_raw = {1'b0, base_q} + {{(FRAME_W+1-WIN_W){1'b0}}, win_eff} - (FRAME_W+1)'(1);
  assign limit_c   = (limit_raw > {1'b0, total_sat}) ? total_sat : limit_raw[FRAME_W-1:0];

  assign k_idx     = k_q[IDX_W-1:0];
  assign frame_cur = {1'b0, base_q} + {{(FRAME_W+1-CNT_W){1'b0}}, k_q};
  assign out_free  = !out_valid_q || out_ready_i;

  assign status_o.start_cmd  = (in_cmd_i == CMD_START);
  assign status_o.round_done = (base_q > total_sat);
  assign status_o.scan_end   = k_q[IDX_W] || (frame_cur >= {1'b0, next_q});
  assign status_o.scan_acked = acked_q[k_idx];
  assign status_o.slide_more = (base_q <= total_sat) && acked_q[0];
  assign status_o.out_free   = out_free;

  always_comb begin
    next_d = next_q;
    if (cmd_i.begin_round && (next_q <= limit_c)) begin
      next_d = limit_c + FRAME_ONE;
    end else if (cmd_i.slide_end && (next_q < base_q)) begin
      next_d = base_q;
    end
  end

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= FRAME_ONE;
      next_q  <= FRAME_ONE;
      acked_q <= '0;
    end else if (cmd_i.clear_win) begin
      base_q  <= FRAME_ONE;
      next_q  <= FRAME_ONE;
      acked_q <= '0;
    end else begin
      next_q <= next_d;
      if (cmd_i.scan_emit) begin
        acked_q[k_idx] <= mask_q[k_idx];
      end else if (cmd_i.slide_step) begin
        acked_q <= {1'b0, acked_q[MAX_WIN-1:1]};
        base_q  <= base_q + FRAME_ONE;
      end
    end
  end

  // per-round snapshot and slot counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      old_base_q <= cmd_i.clear_win ? FRAME_ONE : base_q;
      old_next_q <= next_q;
      mask_q     <= in_delivered_mask_i;
      k_q        <= '0;
    end else if (cmd_i.scan_step) begin
      k_q <= k_q + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.scan_emit || cmd_i.emit_sum) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_emit) begin
      frame_num_q <= frame_cur[FRAME_W-1:0];
      is_new_q    <= (frame_cur >= {1'b0, old_next_q});
      deliv_q     <= mask_q[k_idx];
      summary_q   <= 1'b0;
      win_base_q  <= '0;
      moved_q     <= 1'b0;
      done_q      <= 1'b0;
    end else if (cmd_i.emit_sum) begin
      frame_num_q <= '0;
      is_new_q    <= 1'b0;
      deliv_q     <= 1'b0;
      summary_q   <= 1'b1;
      win_base_q  <= base_q;
      moved_q     <= (base_q > old_base_q);
      done_q      <= (base_q > total_sat);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_frame_number_o = frame_num_q;
  assign out_is_new_o       = is_new_q;
  assign out_delivered_o    = deliv_q;
  assign out_is_summary_o   = summary_q;
  assign out_window_base_o  = win_base_q;
  assign out_base_moved_o   = moved_q;
  assign out_all_done_o     = done_q;
  assign out_last_o         = summary_q;

endmodule

/* hw/rtl/selective_repeat_sender_window_top.sv */
// -----------------------------------------------------------------------------
// selective_repeat_sender_window_top
// Selective-repeat ARQ sender window tracker: admits frames, transmits every
// unacknowledged in-flight frame and slides the base once a round.
// -----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in       | in        | in_valid/in_ready    | cmd, delivered_mask
//  out      | out       | out_valid/out_ready  | frame result or round summary
//  apb      | in        | psel/penable, pready | total_frames, window_size
//
//  Steps: a round request is accepted, then scans the window slots (up to 16)
//  one by one, slides the base one slot at a time (up to 16) and emits the
//  summary. Start and finished-run requests are accepted and go straight to
//  the summary.
//  Reset: window cleared, base and next at frame one, registers at 8 and 4.
//  Stalls: out_ready low holds the scan on the pending slot; in_ready is high
//  only between requests, while the last summary may still be waiting.
//
module selective_repeat_sender_window_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_cmd_i,
  input  logic [srsw_pkg::MAX_WIN-1:0] in_delivered_mask_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srsw_pkg::FRAME_W-1:0] out_frame_number_o,
  output logic                         out_is_new_o,
  output logic                         out_delivered_o,
  output logic                         out_is_summary_o,
  output logic [srsw_pkg::FRAME_W-1:0] out_window_base_o,
  output logic                         out_base_moved_o,
  output logic                         out_all_done_o,
  output logic                         out_last_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srsw_pkg::ADDR_W-1:0]  paddr,
  input  logic [srsw_pkg::DATA_W-1:0]  pwdata,
  output logic [srsw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import srsw_pkg::*;

  logic [FRAME_W-1:0] total;
  logic [WIN_W-1:0]   window;
  srsw_cmd_t          cmd;
  srsw_status_t       status;

  // only change registers between requests (not enforced): datapath reads live
  srsw_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .total_o  (total),
    .window_o (window)
  );

  // sequencer: one-hot state machine, drives the datapath by command struct
  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: window state, slot counter and the registered result
  srsw_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .total_i             (total),
    .window_i            (window),
    .in_cmd_i            (in_cmd_i),
    .in_delivered_mask_i (in_delivered_mask_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_frame_number_o  (out_frame_number_o),
    .out_is_new_o        (out_is_new_o),
    .out_delivered_o     (out_delivered_o),
    .out_is_summary_o    (out_is_summary_o),
    .out_window_base_o   (out_window_base_o),
    .out_base_moved_o    (out_base_moved_o),
    .out_all_done_o      (out_all_done_o),
    .out_last_o          (out_last_o)
  );

endmodule

/* hw/rtl/srsw_checker.sv */
// -----------------------------------------------------------------------------
// srsw_checker
// Port-level checks on the sender window, bound to the top level.
// -----------------------------------------------------------------------------
module srsw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [srsw_pkg::FRAME_W-1:0] out_frame_number_o,
  input logic                         out_is_summary_o,
  input logic [srsw_pkg::FRAME_W-1:0] out_window_base_o,
  input logic                         out_base_moved_o,
  input logic                         out_all_done_o,
  input logic                         out_last_o
);
  import srsw_pkg::*;

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one request at a time: the sequencer is busy right after an accept
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while round in progress");

  // summary closes the request and carries no frame number
  a_summary_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_is_summary_o |-> out_last_o && (out_frame_number_o == '0)
      && (out_window_base_o != '0))
    else $error("malformed summary");

  // frame results carry a frame and no summary fields
  a_frame_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_is_summary_o |-> !out_last_o && (out_frame_number_o != '0)
      && (out_window_base_o == '0) && !out_base_moved_o && !out_all_done_o)
    else $error("malformed frame result");

endmodule

bind selective_repeat_sender_window_top srsw_checker u_srsw_checker (.*);
